// ----- hdl/sbqm_pkg.sv -----
// Shared types and constants for the stereo low-pass biquad mixer.
// Holds the fixed-point widths, the config register codes and the
// structs that run between the lanes, the merge stage and the top level.
package sbqm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 24;
  localparam int FRAC_C   = COEF_W - 2;
  localparam int HIST_W   = SAMPLE_W + 8;
  localparam int XS_W     = SAMPLE_W + 3;
  localparam int PROD_W   = COEF_W + HIST_W;
  localparam int ACC_W    = PROD_W + 2;
  localparam int RQ_W     = ACC_W - FRAC_C;
  localparam int LVL_W    = 7;
  localparam int GAIN_W   = 2 * LVL_W;
  localparam int DRY_P_W  = GAIN_W + SAMPLE_W + 1;
  localparam int N_W      = GAIN_W + HIST_W + 2;
  localparam int CFG_W    = COEF_W;

  // Mix divides by 10000 and rounds half away from zero.
  localparam longint MIX_DEN  = 10000;
  localparam longint MIX_HALF = MIX_DEN / 2;
  // Magnitudes at or above this saturate in either sign.
  localparam longint SAT_LIM  = (longint'(2) ** (SAMPLE_W - 1) + 1) * MIX_DEN;
  localparam int     REM_W    = $clog2(SAT_LIM);

  // Divide by MIX_DEN as a multiply by the rounded-up reciprocal; the
  // reciprocal error stays below 2^(RCP_SH-REM_W), so the quotient is exact
  // for every magnitude below 2^REM_W.
  localparam int RCP_SH = REM_W + $clog2(MIX_DEN);
  localparam int RCP_W  = REM_W + 1;
  localparam int PRQ_W  = REM_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP_MUL =
    RCP_W'(((longint'(1) <<< RCP_SH) + MIX_DEN - 1) / MIX_DEN);

  localparam logic [ACC_W-1:0] ACC_RND = ACC_W'(1) << (FRAC_C - 1);
  localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(MIX_DEN);

  localparam logic signed [HIST_W-1:0] HIST_MAX = {1'b0, {(HIST_W-1){1'b1}}};
  localparam logic signed [HIST_W-1:0] HIST_MIN = {1'b1, {(HIST_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef enum logic [2:0] {
    CFG_B0     = 3'd0,
    CFG_A1     = 3'd1,
    CFG_A2     = 3'd2,
    CFG_DRY    = 3'd3,
    CFG_WET    = 3'd4,
    CFG_BYPASS = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [COEF_W-2:0]          b0;
    logic signed [COEF_W-1:0]   a1;
    logic signed [COEF_W-1:0]   a2;
    logic [GAIN_W-1:0]          wet_gain;
    logic [GAIN_W-1:0]          dry_gain;
  } coef_t;

  typedef struct packed {
    logic start;
    logic ack;
  } lane_ctl_t;

  typedef struct packed {
    logic                       idle;
    logic                       done;
    logic signed [SAMPLE_W-1:0] mix;
  } lane_stat_t;

endpackage

// ----- hdl/sbqm_lane.sv -----
// One channel of the mixer: direct form I biquad plus dry/wet mix.
// Uses sbqm_pkg; a one-hot sequencer drives a shared multiplier register,
// an accumulator and a reciprocal multiply that divides by 10000 in the ST_DIV state.
module sbqm_lane (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sbqm_pkg::coef_t                     coef,
  input  sbqm_pkg::lane_ctl_t                 ctl,
  input  logic signed [sbqm_pkg::SAMPLE_W-1:0] x_in,
  output sbqm_pkg::lane_stat_t                stat
);
  import sbqm_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_FF    = 12'b0000_0000_0010,
    ST_FB1   = 12'b0000_0000_0100,
    ST_FB2   = 12'b0000_0000_1000,
    ST_ACC   = 12'b0000_0001_0000,
    ST_ROUND = 12'b0000_0010_0000,
    ST_MIX   = 12'b0000_0100_0000,
    ST_SUM   = 12'b0000_1000_0000,
    ST_ABS   = 12'b0001_0000_0000,
    ST_CHK   = 12'b0010_0000_0000,
    ST_DIV   = 12'b0100_0000_0000,
    ST_DONE  = 12'b1000_0000_0000
  } lane_st_t;

  lane_st_t state_r, state_nxt;

  // filter history
  logic signed [SAMPLE_W-1:0] x1_r, x2_r;
  logic signed [HIST_W-1:0]   y1_r, y2_r;

  // datapath
  logic signed [SAMPLE_W-1:0] x0_r;
  logic signed [XS_W-1:0]     xs_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [DRY_P_W-1:0]  prod2_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [HIST_W-1:0]   y0_r;
  logic signed [N_W-1:0]      n_r;
  logic [N_W-1:0]             mr_r;
  logic                       neg_r;
  logic                       ovf_r;
  logic [REM_W-1:0]           rem_r;
  logic [SAMPLE_W-1:0]        q_r;

  logic signed [ACC_W-1:0]    rnd_sum;
  logic signed [RQ_W-1:0]     rnd_q;
  logic signed [HIST_W-1:0]   y_sat;
  logic                       rnd_fits;
  logic [PRQ_W-1:0]           rcp_prod;
  logic signed [SAMPLE_W-1:0] mix_res;

  always_comb begin
    rnd_sum  = acc_r + $signed(ACC_RND);
    rnd_q    = rnd_sum[ACC_W-1:FRAC_C];
    rnd_fits = (&rnd_q[RQ_W-1:HIST_W-1]) || (~|rnd_q[RQ_W-1:HIST_W-1]);
    if (rnd_fits) begin
      y_sat = rnd_q[HIST_W-1:0];
    end else if (rnd_q[RQ_W-1]) begin
      y_sat = HIST_MIN;
    end else begin
      y_sat = HIST_MAX;
    end
  end

  assign rcp_prod = rem_r * RCP_MUL;

  always_comb begin
    if (ovf_r) begin
      mix_res = neg_r ? SMP_MIN : SMP_MAX;
    end else if (neg_r) begin
      mix_res = $signed(SAMPLE_W'(~q_r + SAMPLE_W'(1)));
    end else if (q_r[SAMPLE_W-1]) begin
      mix_res = SMP_MAX;
    end else begin
      mix_res = $signed(q_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (ctl.start) state_nxt = ST_FF;
      ST_FF:    state_nxt = ST_FB1;
      ST_FB1:   state_nxt = ST_FB2;
      ST_FB2:   state_nxt = ST_ACC;
      ST_ACC:   state_nxt = ST_ROUND;
      ST_ROUND: state_nxt = ST_MIX;
      ST_MIX:   state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_ABS;
      ST_ABS:   state_nxt = ST_CHK;
      ST_CHK:   state_nxt = ST_DIV;
      ST_DIV:   state_nxt = ST_DONE;
      ST_DONE:  if (ctl.ack) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      x1_r    <= '0;
      x2_r    <= '0;
      y1_r    <= '0;
      y2_r    <= '0;
    end else begin
      state_r <= state_nxt;
      // advance the history only once the result has left the lane
      if (state_r == ST_DONE && ctl.ack) begin
        x2_r <= x1_r;
        x1_r <= x0_r;
        y2_r <= y1_r;
        y1_r <= y0_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        x0_r <= x_in;
        xs_r <= XS_W'(x_in) + (XS_W'(x1_r) <<< 1) + XS_W'(x2_r);
      end
      ST_FF: begin
        prod_r <= $signed({1'b0, coef.b0}) * xs_r;
      end
      ST_FB1: begin
        acc_r  <= ACC_W'(prod_r);
        prod_r <= coef.a1 * y1_r;
      end
      ST_FB2: begin
        acc_r  <= acc_r - ACC_W'(prod_r);
        prod_r <= coef.a2 * y2_r;
      end
      ST_ACC: begin
        acc_r <= acc_r - ACC_W'(prod_r);
      end
      ST_ROUND: begin
        y0_r <= y_sat;
      end
      ST_MIX: begin
        prod_r  <= $signed({1'b0, coef.wet_gain}) * y0_r;
        prod2_r <= $signed({1'b0, coef.dry_gain}) * x0_r;
      end
      ST_SUM: begin
        n_r <= N_W'(prod_r) + N_W'(prod2_r);
      end
      ST_ABS: begin
        neg_r <= n_r[N_W-1];
        if (n_r[N_W-1]) begin
          mr_r <= N_W'(MIX_HALF) - $unsigned(n_r);
        end else begin
          mr_r <= $unsigned(n_r) + N_W'(MIX_HALF);
        end
      end
      ST_CHK: begin
        ovf_r <= (mr_r >= N_W'(SAT_LIM));
        rem_r <= mr_r[REM_W-1:0];
      end
      ST_DIV: begin
        // only used when the magnitude is in range, so the quotient fits
        q_r <= rcp_prod[RCP_SH +: SAMPLE_W];
      end
      default: begin
      end
    endcase
  end

  assign stat.idle = (state_r == ST_IDLE);
  assign stat.done = (state_r == ST_DONE);
  assign stat.mix  = mix_res;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> state_r == ST_IDLE)
    else $error("lane started while busy");

  a_ack_done: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ack |-> state_r == ST_DONE)
    else $error("lane acknowledged without a result");

  a_div_one: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |=> state_r == ST_DONE)
    else $error("divide took more than one cycle");

endmodule

// ----- hdl/sbqm_merge.sv -----
// Merge stage: joins the two lane results, or a bypassed frame, into one
// output register with valid/ready. Uses sbqm_pkg for the lane status type.
module sbqm_merge (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  sbqm_pkg::lane_stat_t                 lane_l,
  input  sbqm_pkg::lane_stat_t                 lane_r,
  input  logic                                 bp_load,
  input  logic signed [sbqm_pkg::SAMPLE_W-1:0] bp_left,
  input  logic signed [sbqm_pkg::SAMPLE_W-1:0] bp_right,
  output logic                                 free,
  output logic                                 lane_ack,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [sbqm_pkg::SAMPLE_W-1:0] out_left,
  output logic signed [sbqm_pkg::SAMPLE_W-1:0] out_right
);
  import sbqm_pkg::*;

  logic                       valid_r;
  logic signed [SAMPLE_W-1:0] left_r, right_r;

  assign free     = !valid_r || out_ready;
  assign lane_ack = lane_l.done && lane_r.done && free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (lane_ack || bp_load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (bp_load) begin
      left_r  <= bp_left;
      right_r <= bp_right;
    end else if (lane_ack) begin
      left_r  <= lane_l.mix;
      right_r <= lane_r.mix;
    end
  end

  assign out_valid = valid_r;
  assign out_left  = left_r;
  assign out_right = right_r;

  a_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(bp_load && lane_ack))
    else $error("bypass item and lane result loaded together");

  a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    lane_l.done == lane_r.done)
    else $error("lanes out of step");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !out_ready |=> valid_r && $stable(left_r) && $stable(right_r))
    else $error("pending item changed before it was taken");

endmodule

// ----- hdl/stereo_biquad_lowpass_mix_unit.sv -----
// Stereo low-pass biquad with dry/wet mix: top level.
// Holds the config registers and instantiates two sbqm_lane and sbqm_merge.
//
// Each item is one stereo frame; left and right run in two identical lanes in
// lockstep. A filtered frame runs from acceptance until the result is in the
// output register: multiply, accumulate, round, mix and range check through
// each lane's product register, then the divide by 10000, done as a multiply
// by its reciprocal, then the hand-over. No new frame is taken before the
// lanes hand over; the next frame can be taken from the cycle after, so a
// frame may enter while the previous result still waits at the output; a
// result that finds the output register full holds the lanes, and with them
// the input, until it is taken. In bypass a frame goes straight to the output
// register and the filter history stays as it is.
// Config writes are always taken (cfg_ready is tied high) and are meant to
// happen only while the block is idle.
module stereo_biquad_lowpass_mix_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [sbqm_pkg::SAMPLE_W-1:0] in_left,
  input  logic signed [sbqm_pkg::SAMPLE_W-1:0] in_right,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [sbqm_pkg::SAMPLE_W-1:0] out_left,
  output logic signed [sbqm_pkg::SAMPLE_W-1:0] out_right,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [2:0]                           cfg_index,
  input  logic [sbqm_pkg::CFG_W-1:0]           cfg_data
);
  import sbqm_pkg::*;

  coef_t      coef_r;
  logic       bypass_r;
  lane_ctl_t  ctl;
  lane_stat_t stat_l, stat_r;
  logic       free;
  logic       lane_ack;
  logic       in_acc;
  logic       bp_load;
  logic       lanes_idle;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.b0       <= '0;
      coef_r.a1       <= '0;
      coef_r.a2       <= '0;
      coef_r.wet_gain <= GAIN_RST;
      coef_r.dry_gain <= GAIN_RST;
      bypass_r        <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_B0:     coef_r.b0 <= cfg_data[COEF_W-2:0];
        CFG_A1:     coef_r.a1 <= $signed(cfg_data[COEF_W-1:0]);
        CFG_A2:     coef_r.a2 <= $signed(cfg_data[COEF_W-1:0]);
        // store the gain, not the level
        CFG_DRY:    coef_r.dry_gain <= cfg_data[LVL_W-1:0] * cfg_data[LVL_W-1:0];
        CFG_WET:    coef_r.wet_gain <= cfg_data[LVL_W-1:0] * cfg_data[LVL_W-1:0];
        CFG_BYPASS: bypass_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign lanes_idle = stat_l.idle && stat_r.idle;
  assign in_ready   = lanes_idle && (!bypass_r || free);
  assign in_acc     = in_valid && in_ready;
  assign bp_load    = in_acc && bypass_r;
  assign ctl.start  = in_acc && !bypass_r;
  assign ctl.ack    = lane_ack;

  sbqm_lane u_lane_l (
    .clk   (clk),
    .rst_n (rst_n),
    .coef  (coef_r),
    .ctl   (ctl),
    .x_in  (in_left),
    .stat  (stat_l)
  );

  sbqm_lane u_lane_r (
    .clk   (clk),
    .rst_n (rst_n),
    .coef  (coef_r),
    .ctl   (ctl),
    .x_in  (in_right),
    .stat  (stat_r)
  );

  sbqm_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .lane_l    (stat_l),
    .lane_r    (stat_r),
    .bp_load   (bp_load),
    .bp_left   (in_left),
    .bp_right  (in_right),
    .free      (free),
    .lane_ack  (lane_ack),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_left  (out_left),
    .out_right (out_right)
  );

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |=> !stat_l.idle && !stat_r.idle)
    else $error("filtered item did not start both lanes");

  a_bp_out: assert property (@(posedge clk) disable iff (!rst_n)
    bp_load |=> out_valid && out_left == $past(in_left) && out_right == $past(in_right))
    else $error("bypassed item not passed through");

  a_idle_pair: assert property (@(posedge clk) disable iff (!rst_n)
    stat_l.idle == stat_r.idle)
    else $error("lanes disagree on idle");

endmodule
